>>> rtl/ldo_pkg.sv
// Shared types, register codes and observer gains for the LIP disturbance observer.
// No dependencies; used by the lane, merge stage, top level and checker.

package ldo_pkg;

  localparam int DATA_W      = 32;
  localparam int IN_TDATA_W  = 192;  // six 32-bit fields
  localparam int IN_TUSER_W  = 2;    // enable, restart
  localparam int OUT_TDATA_W = 256;  // eight 32-bit estimates
  localparam int CFG_ADDR_W  = 3;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_COSH      = 3'd0,
    REG_SINH_ETA  = 3'd1,
    REG_ETA_SINH  = 3'd2,
    REG_STEP      = 3'd3,
    REG_RATE_GAIN = 3'd4,
    REG_OFFSET_X  = 3'd5,
    REG_INIT_X    = 3'd6,
    REG_INIT_Y    = 3'd7
  } cfg_reg_t;

  localparam logic [31:0] COSH_RST      = 32'd65581;
  localparam logic [31:0] SINH_ETA_RST  = 32'd655;
  localparam logic [31:0] ETA_SINH_RST  = 32'd8926;
  localparam logic [30:0] STEP_RST      = 31'd655;
  localparam logic [31:0] RATE_GAIN_RST = 32'd0;
  localparam logic [31:0] OFFSET_X_RST  = 32'd3277;
  localparam logic [31:0] INIT_X_RST    = 32'd0;
  localparam logic [31:0] INIT_Y_RST    = 32'd0;

  // control from the pipeline to both lanes
  typedef struct packed {
    logic s1_go;    // latch products
    logic s2_go;    // commit new state
    logic restart;
    logic update;
  } lane_ctl_t;

  // observer gain matrix G in units of 1e-5, row-major 4x2 (pos, zmp columns)
  localparam longint GAIN_E5 [8] = '{
    64'sd90131, 64'sd0, 64'sd2618387, 64'sd3266,
    64'sd0, 64'sd50000, 64'sd23994774, 64'sd653262
  };

  // gain rounded to nearest with frac fraction bits
  function automatic longint gain_q(input int idx, input int frac);
    return (GAIN_E5[idx] * (longint'(1) << frac) + 64'sd50000) / 64'sd100000;
  endfunction

endpackage

>>> rtl/ldo_lane.sv
// One observer lane: four-state estimate register and its two-step update.
// Depends on ldo_pkg (lane_ctl_t, gain table).

module ldo_lane #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ldo_pkg::lane_ctl_t               ctl,
  input  logic signed [WORD_BITS-1:0]      ch,
  input  logic signed [WORD_BITS-1:0]      soe,
  input  logic signed [WORD_BITS-1:0]      es,
  input  logic signed [WORD_BITS-1:0]      t,
  input  logic signed [WORD_BITS-1:0]      rgf,
  input  logic signed [WORD_BITS-1:0]      omc,
  input  logic signed [WORD_BITS-1:0]      init_dist,
  input  logic signed [WORD_BITS-1:0]      m_pos,
  input  logic signed [WORD_BITS-1:0]      m_zmp,
  input  logic signed [WORD_BITS-1:0]      u,
  output logic [3:0][WORD_BITS-1:0]        est_nxt
);

  // gains reach about 240, so they carry eight integer bits plus sign
  localparam int GW = FRAC_BITS + 9;
  localparam int PW = WORD_BITS + ((WORD_BITS > GW) ? WORD_BITS : GW);
  localparam int SW = WORD_BITS + 3;
  localparam longint WMAX = (longint'(1) << (WORD_BITS - 1)) - 1;
  localparam longint WMIN = -WMAX - 1;
  localparam logic signed [PW:0]   P_MAX = (PW+1)'(WMAX);
  localparam logic signed [PW:0]   P_MIN = (PW+1)'(WMIN);
  localparam logic signed [PW:0]   HALF  = (PW+1)'(longint'(1) << (FRAC_BITS - 1));
  localparam logic signed [SW-1:0] S_MAX = SW'(WMAX);
  localparam logic signed [SW-1:0] S_MIN = SW'(WMIN);

  // nonzero entries of G; the zmp column of row 0 and the pos column of row 2 are zero
  localparam logic signed [GW-1:0] G_POS_P = GW'(ldo_pkg::gain_q(0, FRAC_BITS));
  localparam logic signed [GW-1:0] G_VEL_P = GW'(ldo_pkg::gain_q(2, FRAC_BITS));
  localparam logic signed [GW-1:0] G_VEL_Z = GW'(ldo_pkg::gain_q(3, FRAC_BITS));
  localparam logic signed [GW-1:0] G_ZMP_Z = GW'(ldo_pkg::gain_q(5, FRAC_BITS));
  localparam logic signed [GW-1:0] G_DST_P = GW'(ldo_pkg::gain_q(6, FRAC_BITS));
  localparam logic signed [GW-1:0] G_DST_Z = GW'(ldo_pkg::gain_q(7, FRAC_BITS));

  // product slots
  localparam int P_CH_POS  = 0;
  localparam int P_SOE_VEL = 1;
  localparam int P_OMC_ZMP = 2;
  localparam int P_RGF_U   = 3;
  localparam int P_ES_POS  = 4;
  localparam int P_CH_VEL  = 5;
  localparam int P_ES_ZMP  = 6;
  localparam int P_T_DST   = 7;
  localparam int P_OMC_U   = 8;
  localparam int P_T_U     = 9;
  localparam int P_GPP     = 10;
  localparam int P_GVP     = 11;
  localparam int P_GVZ     = 12;
  localparam int P_GZZ     = 13;
  localparam int P_GDP     = 14;
  localparam int P_GDZ     = 15;
  localparam int NPROD     = 16;

  function automatic logic signed [PW-1:0] mul_ww(input logic signed [WORD_BITS-1:0] a,
                                                  input logic signed [WORD_BITS-1:0] b);
    logic signed [PW-1:0] ea;
    logic signed [PW-1:0] eb;
    ea = PW'(a);
    eb = PW'(b);
    return ea * eb;
  endfunction

  function automatic logic signed [PW-1:0] mul_gw(input logic signed [GW-1:0] g,
                                                  input logic signed [WORD_BITS-1:0] b);
    logic signed [PW-1:0] eg;
    logic signed [PW-1:0] eb;
    eg = PW'(g);
    eb = PW'(b);
    return eg * eb;
  endfunction

  // round half up, drop fraction bits, saturate to the word
  function automatic logic signed [WORD_BITS-1:0] q_round(input logic signed [PW-1:0] p);
    logic signed [PW:0] r;
    r = (PW+1)'(p) + HALF;
    r = r >>> FRAC_BITS;
    if (r > P_MAX) return WORD_BITS'(WMAX);
    if (r < P_MIN) return WORD_BITS'(WMIN);
    return WORD_BITS'(r);
  endfunction

  function automatic logic signed [WORD_BITS-1:0] sat_s(input logic signed [SW-1:0] v);
    if (v > S_MAX) return WORD_BITS'(WMAX);
    if (v < S_MIN) return WORD_BITS'(WMIN);
    return WORD_BITS'(v);
  endfunction

  function automatic logic signed [SW-1:0] qx(input logic signed [PW-1:0] p);
    return SW'(q_round(p));
  endfunction

  logic signed [WORD_BITS-1:0] pos_r, vel_r, zmp_r, dist_r;
  logic signed [WORD_BITS-1:0] pos_nxt, vel_nxt, zmp_nxt, dist_nxt;
  logic signed [WORD_BITS-1:0] ep, ez;
  logic signed [PW-1:0]        prod_nxt [NPROD];
  logic signed [PW-1:0]        prod_r   [NPROD];
  logic signed [SW-1:0]        n_pos, n_vel, n_zmp, n_dist;

  // stage 1: innovations and all products against the settled state
  always_comb begin
    ep = sat_s(SW'(pos_r) - SW'(m_pos));
    ez = sat_s(SW'(zmp_r) - SW'(m_zmp));
    prod_nxt[P_CH_POS]  = mul_ww(ch, pos_r);
    prod_nxt[P_SOE_VEL] = mul_ww(soe, vel_r);
    prod_nxt[P_OMC_ZMP] = mul_ww(omc, zmp_r);
    prod_nxt[P_RGF_U]   = mul_ww(rgf, u);
    prod_nxt[P_ES_POS]  = mul_ww(es, pos_r);
    prod_nxt[P_CH_VEL]  = mul_ww(ch, vel_r);
    prod_nxt[P_ES_ZMP]  = mul_ww(es, zmp_r);
    prod_nxt[P_T_DST]   = mul_ww(t, dist_r);
    prod_nxt[P_OMC_U]   = mul_ww(omc, u);
    prod_nxt[P_T_U]     = mul_ww(t, u);
    prod_nxt[P_GPP]     = mul_gw(G_POS_P, ep);
    prod_nxt[P_GVP]     = mul_gw(G_VEL_P, ep);
    prod_nxt[P_GVZ]     = mul_gw(G_VEL_Z, ez);
    prod_nxt[P_GZZ]     = mul_gw(G_ZMP_Z, ez);
    prod_nxt[P_GDP]     = mul_gw(G_DST_P, ep);
    prod_nxt[P_GDZ]     = mul_gw(G_DST_Z, ez);
  end

  always_ff @(posedge clk) begin
    if (ctl.s1_go) begin
      prod_r <= prod_nxt;
    end
  end

  // stage 2: round each product, exact sum, one saturation per entry
  always_comb begin
    n_pos  = qx(prod_r[P_CH_POS]) + qx(prod_r[P_SOE_VEL]) + qx(prod_r[P_OMC_ZMP])
           + qx(prod_r[P_RGF_U]) - qx(prod_r[P_GPP]);
    n_vel  = qx(prod_r[P_ES_POS]) + qx(prod_r[P_CH_VEL]) - qx(prod_r[P_ES_ZMP])
           + qx(prod_r[P_T_DST]) + qx(prod_r[P_OMC_U])
           - qx(prod_r[P_GVP]) - qx(prod_r[P_GVZ]);
    n_zmp  = SW'(zmp_r) + qx(prod_r[P_T_U]) - qx(prod_r[P_GZZ]);
    n_dist = SW'(dist_r) - qx(prod_r[P_GDP]) - qx(prod_r[P_GDZ]);

    if (ctl.restart) begin
      pos_nxt  = '0;
      vel_nxt  = '0;
      zmp_nxt  = '0;
      dist_nxt = init_dist;
    end else if (ctl.update) begin
      pos_nxt  = sat_s(n_pos);
      vel_nxt  = sat_s(n_vel);
      zmp_nxt  = sat_s(n_zmp);
      dist_nxt = sat_s(n_dist);
    end else begin
      pos_nxt  = pos_r;
      vel_nxt  = vel_r;
      zmp_nxt  = zmp_r;
      dist_nxt = dist_r;
    end
  end

  // reset clears the whole state to zero; init_dist is loaded only on restart
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      vel_r  <= '0;
      zmp_r  <= '0;
      dist_r <= '0;
    end else if (ctl.s2_go) begin
      pos_r  <= pos_nxt;
      vel_r  <= vel_nxt;
      zmp_r  <= zmp_nxt;
      dist_r <= dist_nxt;
    end
  end

  assign est_nxt = {dist_nxt, zmp_nxt, vel_nxt, pos_nxt};

endmodule

>>> rtl/ldo_merge.sv
// Merge stage: clamps both lanes' estimates to 32 bits and packs the output word.
// Depends on ldo_pkg (output widths).

module ldo_merge #(
  parameter int WORD_BITS = 32
) (
  input  logic                                clk,
  input  logic                                load,
  input  logic [3:0][WORD_BITS-1:0]           est_x,
  input  logic [3:0][WORD_BITS-1:0]           est_y,
  output logic [ldo_pkg::OUT_TDATA_W-1:0]     tdata
);

  localparam int DW = ldo_pkg::DATA_W;
  localparam int EW = (WORD_BITS > DW) ? WORD_BITS : DW;
  localparam logic signed [EW-1:0] O_MAX = EW'(longint'(32'h7FFF_FFFF));
  localparam logic signed [EW-1:0] O_MIN = -O_MAX - EW'(1);

  function automatic logic [DW-1:0] out32(input logic signed [WORD_BITS-1:0] v);
    logic signed [EW-1:0] e;
    e = EW'(v);
    if (e > O_MAX) return DW'(O_MAX);
    if (e < O_MIN) return DW'(O_MIN);
    return DW'(e);
  endfunction

  logic [ldo_pkg::OUT_TDATA_W-1:0] tdata_nxt;
  logic [ldo_pkg::OUT_TDATA_W-1:0] tdata_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      tdata_nxt[DW*i +: DW]       = out32($signed(est_x[i]));
      tdata_nxt[DW*(i + 4) +: DW] = out32($signed(est_y[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tdata_r <= tdata_nxt;
    end
  end

  assign tdata = tdata_r;

endmodule

>>> rtl/lip_disturbance_observer.sv
// Top level of the LIP disturbance observer: config registers, input stage,
// two observer lanes (x, y) and the merge stage. Depends on ldo_pkg, ldo_lane, ldo_merge.
//
//   channel | direction | handshake                 | payload
//   in_     | slave     | in_tvalid / in_tready     | in_tdata 192b, in_tuser 2b
//   out_    | master    | out_tvalid / out_tready   | out_tdata 256b
//   cfg_    | write     | cfg_we                    | cfg_addr 3b, cfg_wdata 32b
//
// A word is taken into the input stage, moves on to the product stage and then
// lands in the output register, raising out_tvalid. The estimate feedback loop
// (innovation and multiply, then round, sum and saturate) spans the product
// stage and the state update, so a word enters the product stage only after the
// previous one has updated the state. Reset is synchronous: it loads register
// defaults and clears the estimates. A stalled output holds the product stage;
// the input stage keeps one word buffered meanwhile.

module lip_disturbance_observer #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // com_pos_x, com_pos_y, zmp_ref_x, zmp_ref_y, zmp_rate_x, zmp_rate_y
  input  logic [ldo_pkg::IN_TDATA_W-1:0]        in_tdata,
  // observe_enable, restart
  input  logic [ldo_pkg::IN_TUSER_W-1:0]        in_tuser,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // est_pos_x, est_vel_x, est_zmp_x, est_dist_x, est_pos_y, est_vel_y,
  // est_zmp_y, est_dist_y
  output logic [ldo_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  input  logic                                  cfg_we,
  input  logic [ldo_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [ldo_pkg::DATA_W-1:0]            cfg_wdata
);

  localparam int DW = ldo_pkg::DATA_W;
  localparam int EW = (WORD_BITS > DW) ? WORD_BITS : DW;
  localparam longint WMAX = (longint'(1) << (WORD_BITS - 1)) - 1;
  localparam longint WMIN = -WMAX - 1;
  localparam logic signed [EW-1:0]        E_MAX = EW'(WMAX);
  localparam logic signed [EW-1:0]        E_MIN = EW'(WMIN);
  // two guard bits: 1.0 needs FRAC_BITS+2 signed bits, which may exceed the word
  localparam logic signed [WORD_BITS+1:0] D_MAX = (WORD_BITS+2)'(WMAX);
  localparam logic signed [WORD_BITS+1:0] D_MIN = (WORD_BITS+2)'(WMIN);
  localparam logic signed [WORD_BITS+1:0] ONE   = (WORD_BITS+2)'(longint'(1) << FRAC_BITS);

  // 32-bit value into the word range
  function automatic logic signed [WORD_BITS-1:0] sat_in(input logic signed [DW-1:0] v);
    logic signed [EW-1:0] e;
    e = EW'(v);
    if (e > E_MAX) return WORD_BITS'(WMAX);
    if (e < E_MIN) return WORD_BITS'(WMIN);
    return WORD_BITS'(e);
  endfunction

  function automatic logic signed [WORD_BITS-1:0] sat_d(input logic signed [WORD_BITS+1:0] v);
    if (v > D_MAX) return WORD_BITS'(WMAX);
    if (v < D_MIN) return WORD_BITS'(WMIN);
    return WORD_BITS'(v);
  endfunction

  // configuration registers
  logic [DW-1:0]   cosh_r, sinh_eta_r, eta_sinh_r, rate_gain_r, offset_x_r, init_x_r, init_y_r;
  logic [DW-2:0]   step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cosh_r      <= ldo_pkg::COSH_RST;
      sinh_eta_r  <= ldo_pkg::SINH_ETA_RST;
      eta_sinh_r  <= ldo_pkg::ETA_SINH_RST;
      step_r      <= ldo_pkg::STEP_RST;
      rate_gain_r <= ldo_pkg::RATE_GAIN_RST;
      offset_x_r  <= ldo_pkg::OFFSET_X_RST;
      init_x_r    <= ldo_pkg::INIT_X_RST;
      init_y_r    <= ldo_pkg::INIT_Y_RST;
    end else if (cfg_we) begin
      unique case (ldo_pkg::cfg_reg_t'(cfg_addr))
        ldo_pkg::REG_COSH:      cosh_r      <= cfg_wdata;
        ldo_pkg::REG_SINH_ETA:  sinh_eta_r  <= cfg_wdata;
        ldo_pkg::REG_ETA_SINH:  eta_sinh_r  <= cfg_wdata;
        ldo_pkg::REG_STEP:      step_r      <= cfg_wdata[DW-2:0];
        ldo_pkg::REG_RATE_GAIN: rate_gain_r <= cfg_wdata;
        ldo_pkg::REG_OFFSET_X:  offset_x_r  <= cfg_wdata;
        ldo_pkg::REG_INIT_X:    init_x_r    <= cfg_wdata;
        ldo_pkg::REG_INIT_Y:    init_y_r    <= cfg_wdata;
      endcase
    end
  end

  // coefficients; the user must keep them static while words are in flight, the block does not enforce it
  logic signed [WORD_BITS-1:0] ch, soe, es, t, rgf, omc, init_x, init_y;

  always_comb begin
    ch     = sat_in(cosh_r);
    soe    = sat_in(sinh_eta_r);
    es     = sat_in(eta_sinh_r);
    t      = sat_in({1'b0, step_r});
    rgf    = sat_in(rate_gain_r);
    omc    = sat_d(ONE - (WORD_BITS+2)'(ch));
    init_x = sat_in(init_x_r);
    init_y = sat_in(init_y_r);
  end

  // pipeline control
  logic s1_valid_r, s2_valid_r, out_valid_r;
  logic s1_restart_r, s1_update_r, s2_restart_r, s2_update_r;
  logic s1_go, s2_go;
  ldo_pkg::lane_ctl_t ctl;

  assign s2_go     = s2_valid_r && (!out_valid_r || out_tready);
  assign s1_go     = s1_valid_r && !s2_valid_r;   // state must be settled
  assign in_tready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      s1_restart_r <= 1'b0;
      s1_update_r  <= 1'b0;
      s2_restart_r <= 1'b0;
      s2_update_r  <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r   <= in_tvalid;
        s1_restart_r <= in_tuser[1];
        s1_update_r  <= in_tuser[0];
      end
      if (s1_go) begin
        s2_valid_r   <= 1'b1;
        s2_restart_r <= s1_restart_r;
        s2_update_r  <= s1_update_r;
      end else if (s2_go) begin
        s2_valid_r <= 1'b0;
      end
      if (s2_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    ctl.s1_go   = s1_go;
    ctl.s2_go   = s2_go;
    ctl.restart = s2_restart_r;
    ctl.update  = s2_update_r;
  end

  // input stage: measurements in the word range, x position offset removed
  logic signed [WORD_BITS-1:0] mx_r, my_r, zx_r, zy_r, ux_r, uy_r;

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      mx_r <= sat_d((WORD_BITS+2)'(sat_in(in_tdata[31:0]))
                  - (WORD_BITS+2)'(sat_in(offset_x_r)));
      my_r <= sat_in(in_tdata[63:32]);
      zx_r <= sat_in(in_tdata[95:64]);
      zy_r <= sat_in(in_tdata[127:96]);
      ux_r <= sat_in(in_tdata[159:128]);
      uy_r <= sat_in(in_tdata[191:160]);
    end
  end

  logic [3:0][WORD_BITS-1:0] est_x, est_y;

  ldo_lane #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_lane_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .ch        (ch),
    .soe       (soe),
    .es        (es),
    .t         (t),
    .rgf       (rgf),
    .omc       (omc),
    .init_dist (init_x),
    .m_pos     (mx_r),
    .m_zmp     (zx_r),
    .u         (ux_r),
    .est_nxt   (est_x)
  );

  ldo_lane #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_lane_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .ch        (ch),
    .soe       (soe),
    .es        (es),
    .t         (t),
    .rgf       (rgf),
    .omc       (omc),
    .init_dist (init_y),
    .m_pos     (my_r),
    .m_zmp     (zy_r),
    .u         (uy_r),
    .est_nxt   (est_y)
  );

  ldo_merge #(
    .WORD_BITS (WORD_BITS)
  ) u_merge (
    .clk   (clk),
    .load  (s2_go),
    .est_x (est_x),
    .est_y (est_y),
    .tdata (out_tdata)
  );

  assign out_tvalid = out_valid_r;

endmodule

>>> rtl/ldo_checker.sv
// Port-level checks for lip_disturbance_observer, attached with a bind.
// Depends on ldo_pkg for port widths.

module ldo_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [ldo_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  // words taken in and not yet delivered
  logic [2:0] pending_r;
  logic [2:0] pending_nxt;

  always_comb begin
    pending_nxt = pending_r;
    if (in_tvalid && in_tready) begin
      pending_nxt = pending_nxt + 3'd1;
    end
    if (out_tvalid && out_tready) begin
      pending_nxt = pending_nxt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pending_r != 3'd0)
    else $error("output word without an input word");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= 3'd3)
    else $error("more words in flight than pipeline stages");

endmodule

bind lip_disturbance_observer ldo_checker u_ldo_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
